/* src/htb_pkg.sv */
package htb_pkg;

  // Default sizes of the tree builder.
  localparam int DEF_LEAVES      = 16;
  localparam int DEF_WEIGHT_BITS = 16;

  // Fixed field widths of the channels.
  localparam int LEAF_W_BITS  = 16;
  localparam int SUM_BITS     = 20;
  localparam int IDX_OUT_BITS = 5;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_TAIL,
    ST_EMIT,
    ST_TRIV
  } htb_state_t;

  // One candidate node handed to the minimum tracker.
  typedef struct packed {
    logic                clr;
    logic                vld;
    logic                taken;
    logic [SUM_BITS-1:0] w;
  } htb_cand_t;

  // Current best and second-best weights held by the tracker.
  typedef struct packed {
    logic                have_a;
    logic                have_b;
    logic [SUM_BITS-1:0] wa;
    logic [SUM_BITS-1:0] wb;
  } htb_pick_t;

endpackage

/* src/htb_if.sv */
// Request channel carrying one leaf weight.
interface htb_in_if import htb_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [LEAF_W_BITS-1:0] leaf_weight;
  logic                   last_leaf;

  modport source (output valid, output leaf_weight, output last_leaf, input ready);
  modport sink   (input valid, input leaf_weight, input last_leaf, output ready);
endinterface

// Result channel carrying one merge of the tree.
interface htb_out_if import htb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_OUT_BITS-1:0] new_node;
  logic [IDX_OUT_BITS-1:0] left_index;
  logic [IDX_OUT_BITS-1:0] right_index;
  logic [SUM_BITS-1:0]     merged_weight;
  logic                    trivial;
  logic                    last_merge;

  modport source (output valid, output new_node, output left_index, output right_index,
                  output merged_weight, output trivial, output last_merge, input ready);
  modport sink   (input valid, input new_node, input left_index, input right_index,
                  input merged_weight, input trivial, input last_merge, output ready);
endinterface

/* src/htb_select.sv */
// Tracks the lowest and second-lowest weights among the free nodes seen
// during one scan. Strict compares keep the earlier index on ties.
module htb_select import htb_pkg::*; #(
  parameter int IDX_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  htb_cand_t        cand,
  input  logic [IDX_W-1:0] cand_idx,
  output htb_pick_t        pick,
  output logic [IDX_W-1:0] a_idx,
  output logic [IDX_W-1:0] b_idx
);

  logic                have_a_r;
  logic                have_b_r;
  logic [SUM_BITS-1:0] wa_r;
  logic [SUM_BITS-1:0] wb_r;
  logic [IDX_W-1:0]    a_r;
  logic [IDX_W-1:0]    b_r;
  logic                use_cand;
  logic                new_min;
  logic                new_second;

  // Decide where the candidate lands.
  assign use_cand   = cand.vld && !cand.taken;
  assign new_min    = use_cand && (!have_a_r || (cand.w < wa_r));
  assign new_second = use_cand && !new_min && (!have_b_r || (cand.w < wb_r));

  // Found flags are control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_a_r <= 1'b0;
      have_b_r <= 1'b0;
    end else if (cand.clr) begin
      have_a_r <= 1'b0;
      have_b_r <= 1'b0;
    end else if (new_min) begin
      have_a_r <= 1'b1;
      have_b_r <= have_a_r;
    end else if (new_second) begin
      have_b_r <= 1'b1;
    end
  end

  // The old minimum moves down to second place when a new minimum appears.
  always_ff @(posedge clk) begin
    if (new_min) begin
      a_r  <= cand_idx;
      wa_r <= cand.w;
      b_r  <= a_r;
      wb_r <= wa_r;
    end else if (new_second) begin
      b_r  <= cand_idx;
      wb_r <= cand.w;
    end
  end

  assign pick.have_a = have_a_r;
  assign pick.have_b = have_b_r;
  assign pick.wa     = wa_r;
  assign pick.wb     = wb_r;
  assign a_idx       = a_r;
  assign b_idx       = b_r;

`ifndef SYNTHESIS
  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    have_b_r |-> have_a_r)
    else $error("second minimum held without a first");

  a_order_kept: assert property (@(posedge clk) disable iff (!rst_n)
    have_b_r |-> (wa_r <= wb_r))
    else $error("minimum weight exceeds second minimum");

  a_clear_works: assert property (@(posedge clk) disable iff (!rst_n)
    cand.clr |=> !have_a_r)
    else $error("tracker not cleared at scan start");
`endif

endmodule

/* src/huffman_tree_builder.sv */
// Channel   Direction  Payload
// in_req    sink       leaf_weight[15:0], last_leaf
// out_res   source     new_node[4:0], left_index[4:0], right_index[4:0],
//                      merged_weight[19:0], trivial, last_merge
//
// A leaf weight is taken whenever the sequencer is in its load state. Building node k
// of a tree reads the weight memory once per older node, then does the last compare,
// and then writes the sum and presents the result.
// Reset is synchronous and active low; the weight memory is not cleared.
// A full output register holds the sequencer in its write cycle until taken.
module huffman_tree_builder import htb_pkg::*; #(
  parameter int LEAVES      = DEF_LEAVES,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input logic       clk,
  input logic       rst_n,
  htb_in_if.sink    in_req,
  htb_out_if.source out_res
);

  localparam int NODES = 2 * LEAVES;
  localparam int IDX_W = $clog2(NODES);
  localparam int CNT_W = $clog2(LEAVES + 1);
  localparam logic [LEAF_W_BITS-1:0] W_MASK = (WEIGHT_BITS >= LEAF_W_BITS) ? '1 :
    LEAF_W_BITS'((64'd1 << WEIGHT_BITS) - 64'd1);

  htb_state_t state_r;
  htb_state_t state_nxt;

  logic [CNT_W-1:0]    cnt_r;
  logic [IDX_W-1:0]    k_r;
  logic [IDX_W-1:0]    scan_j_r;
  logic [IDX_W-1:0]    cmp_j_r;
  logic                cmp_vld_r;
  logic [SUM_BITS-1:0] rd_data_r;
  logic [NODES-1:0]    taken_r;
  logic [SUM_BITS-1:0] weight_mem [NODES];

  logic                    out_vld_r;
  logic [IDX_OUT_BITS-1:0] out_node_r;
  logic [IDX_OUT_BITS-1:0] out_left_r;
  logic [IDX_OUT_BITS-1:0] out_right_r;
  logic [SUM_BITS-1:0]     out_weight_r;
  logic                    out_triv_r;
  logic                    out_last_r;

  logic                in_fire;
  logic                out_free;
  logic                cnt_full;
  logic [CNT_W-1:0]    cnt_after;
  logic [IDX_W-1:0]    last_k;
  logic                is_root;
  logic [SUM_BITS-1:0] leaf_w;
  logic [SUM_BITS-1:0] merge_w;

  logic                in_ready_c;
  logic                rd_en;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [SUM_BITS-1:0] wr_data;
  logic                emit_merge;
  logic                emit_triv;
  logic                set_done;
  logic                sel_clr;

  htb_cand_t        cand;
  htb_pick_t        pick;
  logic [IDX_W-1:0] a_idx;
  logic [IDX_W-1:0] b_idx;

  // Shared conditions.
  assign in_fire   = in_req.valid && in_ready_c;
  assign out_free  = !out_vld_r || out_res.ready;
  assign cnt_full  = (cnt_r == CNT_W'(LEAVES));
  assign cnt_after = cnt_full ? cnt_r : cnt_r + 1'b1;
  assign last_k    = IDX_W'({cnt_r, 1'b0} - 1'b1);
  assign is_root   = (k_r == last_k);
  assign leaf_w    = SUM_BITS'(in_req.leaf_weight & W_MASK);
  assign merge_w   = pick.wa + pick.wb;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_fire && in_req.last_leaf) begin
          state_nxt = (cnt_after < CNT_W'(2)) ? ST_TRIV : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_j_r == k_r - 1'b1) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = is_root ? ST_LOAD : ST_SCAN;
        end
      end
      ST_TRIV: begin
        if (out_free) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // State outputs and memory port control.
  always_comb begin
    in_ready_c = (state_r == ST_LOAD);
    rd_en      = (state_r == ST_SCAN);
    emit_merge = (state_r == ST_EMIT) && out_free;
    emit_triv  = (state_r == ST_TRIV) && out_free;
    set_done   = (emit_merge && is_root) || emit_triv;
    sel_clr    = (state_nxt == ST_SCAN) && (state_r != ST_SCAN);
    wr_en      = (in_fire && !cnt_full) || emit_merge;
    wr_addr    = (state_r == ST_EMIT) ? k_r : IDX_W'(cnt_r) + 1'b1;
    wr_data    = (state_r == ST_EMIT) ? merge_w : leaf_w;
  end

  assign in_req.ready = in_ready_c;

  // Weight memory with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      weight_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= weight_mem[scan_j_r];
      cmp_j_r   <= scan_j_r;
    end
  end

  // Sequencer registers, counters and taken flags.
  // A finished set returns the leaf count, the node index and the taken flags to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      cnt_r     <= '0;
      k_r       <= '0;
      scan_j_r  <= '0;
      cmp_vld_r <= 1'b0;
      taken_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= rd_en;
      if (set_done) begin
        cnt_r <= '0;
      end else if (in_fire && !cnt_full) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (set_done) begin
        k_r <= '0;
      end else if (in_fire && in_req.last_leaf) begin
        k_r <= IDX_W'(cnt_after) + 1'b1;
      end else if (emit_merge) begin
        k_r <= k_r + 1'b1;
      end
      if (sel_clr) begin
        scan_j_r <= IDX_W'(1);
      end else if (rd_en) begin
        scan_j_r <= scan_j_r + 1'b1;
      end
      if (set_done) begin
        taken_r <= '0;
      end else if (emit_merge) begin
        taken_r <= taken_r | (NODES'(1) << a_idx) | (NODES'(1) << b_idx);
      end
      if (emit_merge || emit_triv) begin
        out_vld_r <= 1'b1;
      end else if (out_res.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (emit_merge || emit_triv) begin
      out_node_r   <= emit_triv ? '0 : IDX_OUT_BITS'(k_r);
      out_left_r   <= emit_triv ? '0 : IDX_OUT_BITS'(a_idx);
      out_right_r  <= emit_triv ? '0 : IDX_OUT_BITS'(b_idx);
      out_weight_r <= emit_triv ? '0 : merge_w;
      out_triv_r   <= emit_triv;
      out_last_r   <= emit_triv || is_root;
    end
  end

  assign out_res.valid         = out_vld_r;
  assign out_res.new_node      = out_node_r;
  assign out_res.left_index    = out_left_r;
  assign out_res.right_index   = out_right_r;
  assign out_res.merged_weight = out_weight_r;
  assign out_res.trivial       = out_triv_r;
  assign out_res.last_merge    = out_last_r;

  // Minimum tracker fed by the memory read data.
  assign cand.clr   = sel_clr;
  assign cand.vld   = cmp_vld_r;
  assign cand.taken = taken_r[cmp_j_r];
  assign cand.w     = rd_data_r;

  htb_select #(
    .IDX_W (IDX_W)
  ) u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .cand     (cand),
    .cand_idx (cmp_j_r),
    .pick     (pick),
    .a_idx    (a_idx),
    .b_idx    (b_idx)
  );

`ifndef SYNTHESIS
  a_emit_has_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> pick.have_b)
    else $error("merge written without two free nodes");

  a_children_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit_merge |-> (!taken_r[a_idx] && !taken_r[b_idx]))
    else $error("merge reuses a node that already has a parent");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_j_r < k_r))
    else $error("scan read beyond the nodes built so far");
`endif

endmodule
